/* src/plkm_pkg.sv */
// shared types, register indexes and constants for the layer key and region mask block
`default_nettype none

package plkm_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FIELD_BITS     = 12;
  localparam int REG_BITS       = 24;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [7:0] ALPHA_FULL = 8'd255;
  localparam logic [7:0] ALPHA_NONE = 8'd0;

  localparam logic [1:0] MODE_FULL    = 2'd0;
  localparam logic [1:0] MODE_REGION  = 2'd1;
  localparam logic [1:0] MODE_KEY     = 2'd2;
  localparam logic [1:0] MODE_KEY_INV = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_COLOR   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECT_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECT_SIZE   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_SIZE  = 3'd5;

  localparam logic [REG_BITS-1:0] FRAME_SIZE_RST = 24'd1966720;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [7:0]          tolerance;
    logic [REG_BITS-1:0] key_color;
    logic [REG_BITS-1:0] rect_origin;
    logic [REG_BITS-1:0] rect_size;
    logic [REG_BITS-1:0] frame_size;
  } cfg_t;

  typedef struct packed {
    logic last_col;
    logic last_row;
  } pos_flags_t;

endpackage

`default_nettype wire

/* src/plkm_if.sv */
// channel interfaces: pixel input, pixel result and configuration write
`default_nettype none

interface plkm_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  logic       frame_start;

  modport source (output valid, blue_in, green_in, red_in, frame_start, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, frame_start, output ready);
endinterface

interface plkm_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic [7:0] alpha_out;
  logic       frame_end;

  modport source (output valid, blue_out, green_out, red_out, alpha_out, frame_end,
                  input ready);
  modport sink   (input valid, blue_out, green_out, red_out, alpha_out, frame_end,
                  output ready);
endinterface

interface plkm_cfg_if
  import plkm_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [REG_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/plkm_pixel.sv */
// per-pixel datapath: region test, colour key test and end-of-line flags
`default_nettype none

module plkm_pixel
  import plkm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  pix_in_t                 pix,
  input  logic [COORD_BITS-1:0]   x,
  input  logic [COORD_BITS-1:0]   y,
  input  cfg_t                    cfg,
  output pix_out_t                result,
  output pos_flags_t              flags
);

  localparam int FB = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

  logic [COORD_BITS-1:0] fw_raw, fh_raw, fw, fh;
  logic [COORD_BITS-1:0] org_x, org_y, size_x, size_y;
  logic                  in_rect;
  logic                  match;
  logic                  keep;

  function automatic logic in_span(input logic [COORD_BITS-1:0] pos,
                                   input logic [COORD_BITS-1:0] o,
                                   input logic [COORD_BITS-1:0] s,
                                   input logic [COORD_BITS-1:0] dim);
    logic [COORD_BITS-1:0] start;
    logic [COORD_BITS-1:0] room;
    logic [COORD_BITS-1:0] len;
    logic [COORD_BITS:0]   stop;
    start = (o < dim) ? o : dim;
    room  = dim - start;
    len   = (s < room) ? s : room;
    stop  = {1'b0, start} + {1'b0, len};
    return (pos >= start) && ({1'b0, pos} < stop);
  endfunction

  function automatic logic near(input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] tol);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d <= tol;
  endfunction

  assign fw_raw = COORD_BITS'(cfg.frame_size[FB-1:0]);
  assign fh_raw = COORD_BITS'(cfg.frame_size[FIELD_BITS +: FB]);
  assign fw     = (fw_raw == '0) ? COORD_BITS'(1) : fw_raw;
  assign fh     = (fh_raw == '0) ? COORD_BITS'(1) : fh_raw;
  assign org_x  = COORD_BITS'(cfg.rect_origin[FB-1:0]);
  assign org_y  = COORD_BITS'(cfg.rect_origin[FIELD_BITS +: FB]);
  assign size_x = COORD_BITS'(cfg.rect_size[FB-1:0]);
  assign size_y = COORD_BITS'(cfg.rect_size[FIELD_BITS +: FB]);

  assign in_rect = in_span(x, org_x, size_x, fw) && in_span(y, org_y, size_y, fh);
  assign match  = near(pix.red,   cfg.key_color[23:16], cfg.tolerance) &&
                  near(pix.green, cfg.key_color[15:8],  cfg.tolerance) &&
                  near(pix.blue,  cfg.key_color[7:0],   cfg.tolerance);

  assign flags.last_col = x >= (fw - COORD_BITS'(1));
  assign flags.last_row = y >= (fh - COORD_BITS'(1));

  always_comb begin
    keep = 1'b1;
    result.blue      = pix.blue;
    result.green     = pix.green;
    result.red       = pix.red;
    result.alpha     = ALPHA_FULL;
    result.frame_end = flags.last_col && flags.last_row;
    unique case (cfg.mode)
      MODE_FULL: begin
        keep = 1'b1;
      end
      MODE_REGION: begin
        keep = in_rect;
        if (!in_rect) begin
          result.blue  = 8'd0;
          result.green = 8'd0;
          result.red   = 8'd0;
        end
      end
      MODE_KEY: begin
        keep = !match;
      end
      MODE_KEY_INV: begin
        keep = match;
      end
      default: begin
        keep = 1'b1;
      end
    endcase
    result.alpha = keep ? ALPHA_FULL : ALPHA_NONE;
  end

endmodule

`default_nettype wire

/* src/pixel_layer_key_and_region_mask.sv */
// top level: pixel layer key and region mask with raster position tracking
//
// in_ch carries one BGR pixel per item plus frame_start, which puts the
// pixel at column 0, row 0. out_ch returns one BGRA pixel per input item,
// in order, with frame_end on the last pixel of the frame. cfg_ch writes
// the six registers (mode, tolerance, key colour, rectangle origin and size,
// frame size) by index; it is always ready and should be used only while
// no pixel is in flight. Indexes past the last register are dropped.
// An item passes an input register and then a result register before
// out_ch.valid rises, and one item is taken every cycle while the
// receiver keeps up. The per-pixel compares sit between the
// two registers and set the clock limit. When out_ch.ready is low the result
// holds and the input register still takes one more item before in_ch.ready
// drops. Reset clears both stages, the position to 0, 0 and the registers to
// full frame mode with a 640 x 480 frame.
`default_nettype none

module pixel_layer_key_and_region_mask
  import plkm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  plkm_pix_in_if.sink    in_ch,
  plkm_pix_out_if.source out_ch,
  plkm_cfg_if.sink       cfg_ch
);

  cfg_t                  cfg_r, cfg_nxt;
  logic                  a_valid_r, a_valid_nxt;
  pix_in_t               a_pix_r, a_pix_nxt;
  logic                  out_valid_r, out_valid_nxt;
  pix_out_t              out_pix_r, out_pix_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] x, y;
  pos_flags_t            flags;
  logic                  in_acc;
  logic                  load_b;

  plkm_pixel #(
    .COORD_BITS (COORD_BITS)
  ) u_pixel (
    .pix    (a_pix_r),
    .x      (x),
    .y      (y),
    .cfg    (cfg_r),
    .result (out_pix_nxt),
    .flags  (flags)
  );

  assign load_b       = a_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !a_valid_r || load_b;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign x = a_pix_r.frame_start ? '0 : col_r;
  assign y = a_pix_r.frame_start ? '0 : row_r;

  assign a_pix_nxt.blue        = in_ch.blue_in;
  assign a_pix_nxt.green       = in_ch.green_in;
  assign a_pix_nxt.red         = in_ch.red_in;
  assign a_pix_nxt.frame_start = in_ch.frame_start;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
    end else if (load_b) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load_b) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (load_b) begin
      if (flags.last_col) begin
        col_nxt = '0;
        row_nxt = flags.last_row ? '0 : (y + COORD_BITS'(1));
      end else begin
        col_nxt = x + COORD_BITS'(1);
        row_nxt = y;
      end
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_MODE:        cfg_nxt.mode        = cfg_ch.data[1:0];
        REG_TOLERANCE:   cfg_nxt.tolerance   = cfg_ch.data[7:0];
        REG_KEY_COLOR:   cfg_nxt.key_color   = cfg_ch.data;
        REG_RECT_ORIGIN: cfg_nxt.rect_origin = cfg_ch.data;
        REG_RECT_SIZE:   cfg_nxt.rect_size   = cfg_ch.data;
        REG_FRAME_SIZE:  cfg_nxt.frame_size  = cfg_ch.data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r         <= 1'b0;
      out_valid_r       <= 1'b0;
      col_r             <= '0;
      row_r             <= '0;
      cfg_r.mode        <= MODE_FULL;
      cfg_r.tolerance   <= '0;
      cfg_r.key_color   <= '0;
      cfg_r.rect_origin <= '0;
      cfg_r.rect_size   <= '0;
      cfg_r.frame_size  <= FRAME_SIZE_RST;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix_r <= a_pix_nxt;
    end
    if (load_b) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.blue_out  = out_pix_r.blue;
  assign out_ch.green_out = out_pix_r.green;
  assign out_ch.red_out   = out_pix_r.red;
  assign out_ch.alpha_out = out_pix_r.alpha;
  assign out_ch.frame_end = out_pix_r.frame_end;

  // input side stalls only when both stages hold an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (a_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled with a free stage");

  // end of frame wraps the position
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (load_b && out_pix_nxt.frame_end) |=> (col_r == '0 && row_r == '0))
    else $error("position not wrapped after frame end");

  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pix_r.alpha == ALPHA_FULL || out_pix_r.alpha == ALPHA_NONE))
    else $error("alpha neither opaque nor clear");

  // masked region pixels carry no colour
  a_region_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (load_b && cfg_r.mode == MODE_REGION && out_pix_nxt.alpha == ALPHA_NONE) |=>
      (out_pix_r.blue == 8'd0 && out_pix_r.green == 8'd0 && out_pix_r.red == 8'd0))
    else $error("masked pixel has colour");

endmodule

`default_nettype wire
